// ===== hdl/srrd_pkg.sv =====
// ----------------------------------------------------------------------------
// srrd_pkg: shared types and constants of the sprite row run decoder
// Holds the stream word and result layouts, the decoder phase encoding and
// the configuration register map.
// ----------------------------------------------------------------------------
package srrd_pkg;

	// Widths fixed by the stream and result formats.
	localparam int WORD_W    = 16;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 1;
	localparam int POS_W     = 10;
	localparam int COLOR_W   = 8;
	localparam int COUNT_W   = 16;

	// Configuration register map.
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	// Register values after reset.
	localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 11'd128;
	localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 11'd96;

	// Row codes with a meaning of their own.
	localparam logic [WORD_W-1:0] CODE_BLANK_ROW = 16'd0;
	localparam logic [WORD_W-1:0] CODE_FULL_ROW  = 16'd1;

	// Decoder phase: which kind of word is expected next.
	typedef enum logic [3:0] {
		PH_CODE = 4'b0001,
		PH_SKIP = 4'b0010,
		PH_COPY = 4'b0100,
		PH_PIX  = 4'b1000
	} srrd_phase_t;

	// One result item.
	typedef struct packed {
		logic [POS_W-1:0]   row;
		logic [POS_W-1:0]   column;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic               pixel_valid;
		logic               out_of_row;
		logic               image_done;
	} srrd_result_t;

endpackage

// ===== hdl/srrd_stream_if.sv =====
// ----------------------------------------------------------------------------
// srrd_stream_if: stream word channel
// Valid/ready channel that carries one 16-bit coded sprite word per
// transaction.
// ----------------------------------------------------------------------------
interface srrd_stream_if;
	import srrd_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] stream_word;

	modport source (output valid, output stream_word, input ready);
	modport sink (input valid, input stream_word, output ready);

endinterface

// ===== hdl/srrd_result_if.sv =====
// ----------------------------------------------------------------------------
// srrd_result_if: decoded pixel channel
// Valid/ready channel that carries one decoded pixel or end-of-image mark
// per transaction.
// ----------------------------------------------------------------------------
interface srrd_result_if;
	import srrd_pkg::*;

	logic               valid;
	logic               ready;
	logic [POS_W-1:0]   row;
	logic [POS_W-1:0]   column;
	logic [COLOR_W-1:0] red;
	logic [COLOR_W-1:0] green;
	logic [COLOR_W-1:0] blue;
	logic               pixel_valid;
	logic               out_of_row;
	logic               image_done;

	modport source (
		output valid, output row, output column, output red, output green,
		output blue, output pixel_valid, output out_of_row, output image_done,
		input ready
	);
	modport sink (
		input valid, input row, input column, input red, input green,
		input blue, input pixel_valid, input out_of_row, input image_done,
		output ready
	);

endinterface

// ===== hdl/srrd_step.sv =====
// ----------------------------------------------------------------------------
// srrd_step: decoder next-state and result logic
// Takes the current decoder state and one stream word and gives the state
// after that word together with the result it causes, if any.
// ----------------------------------------------------------------------------
module srrd_step #(
	parameter int MAX_DIM = 1024
) (
	input  srrd_pkg::srrd_phase_t                 phase,
	input  logic [$clog2(MAX_DIM+1)-1:0]          rows_done,
	input  logic [srrd_pkg::COUNT_W-1:0]          runs_left,
	input  logic [srrd_pkg::COUNT_W-1:0]          pixels_left,
	input  logic [$clog2(MAX_DIM+1)-1:0]          column_pos,
	input  logic [srrd_pkg::CFG_W-1:0]            image_width,
	input  logic [srrd_pkg::CFG_W-1:0]            image_height,
	input  logic [srrd_pkg::WORD_W-1:0]           word,
	output srrd_pkg::srrd_phase_t                 phase_nxt,
	output logic [$clog2(MAX_DIM+1)-1:0]          rows_done_nxt,
	output logic [srrd_pkg::COUNT_W-1:0]          runs_left_nxt,
	output logic [srrd_pkg::COUNT_W-1:0]          pixels_left_nxt,
	output logic [$clog2(MAX_DIM+1)-1:0]          column_pos_nxt,
	output logic                                  has_result,
	output srrd_pkg::srrd_result_t                result
);
	import srrd_pkg::*;

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int CMP_W = (DIM_W > CFG_W) ? DIM_W : CFG_W;
	localparam int SUM_W = ((DIM_W > WORD_W) ? DIM_W : WORD_W) + 1;

	// Limits a register value to the range 1..MAX_DIM.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (CMP_W'(v) > CMP_W'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

	logic [DIM_W-1:0] wid;
	logic [DIM_W-1:0] hgt;
	logic [SUM_W-1:0] skip_sum;
	logic [DIM_W-1:0] row_out;
	logic             last_row;
	logic             do_end_run;
	logic             do_finish;
	logic             done;

	assign wid = clamp_dim(image_width);
	assign hgt = clamp_dim(image_height);

	// Column after a skip, and the output row counted from the bottom.
	assign skip_sum = SUM_W'(column_pos) + SUM_W'(word);
	assign row_out  = (rows_done < hgt) ? (hgt - DIM_W'(1) - rows_done) : '0;
	assign last_row = ((DIM_W + 1)'(rows_done) + (DIM_W + 1)'(1)) >= (DIM_W + 1)'(hgt);

	always_comb begin
		phase_nxt       = phase;
		rows_done_nxt   = rows_done;
		runs_left_nxt   = runs_left;
		pixels_left_nxt = pixels_left;
		column_pos_nxt  = column_pos;
		has_result      = 1'b0;
		result          = '0;
		do_end_run      = 1'b0;
		do_finish       = 1'b0;
		done            = 1'b0;

		// Decode the word according to the phase.
		case (phase)
			PH_CODE: begin
				column_pos_nxt = '0;
				if (word == CODE_BLANK_ROW) begin
					do_finish = 1'b1;
				end else if (word == CODE_FULL_ROW) begin
					runs_left_nxt   = COUNT_W'(1);
					pixels_left_nxt = COUNT_W'(wid);
					phase_nxt       = PH_PIX;
				end else begin
					runs_left_nxt = word - COUNT_W'(1);
					phase_nxt     = PH_SKIP;
				end
			end
			PH_SKIP: begin
				if (skip_sum > SUM_W'(MAX_DIM)) begin
					column_pos_nxt = DIM_W'(MAX_DIM);
				end else begin
					column_pos_nxt = DIM_W'(skip_sum);
				end
				phase_nxt = PH_COPY;
			end
			PH_COPY: begin
				pixels_left_nxt = word;
				if (word == '0) begin
					do_end_run = 1'b1;
				end else begin
					phase_nxt = PH_PIX;
				end
			end
			PH_PIX: begin
				has_result    = 1'b1;
				result.row    = POS_W'(row_out);
				result.column = POS_W'(column_pos);
				if (column_pos < wid) begin
					// RGB565 to RGB888 by plain shifts.
					result.red         = {word[15:11], 3'b000};
					result.green       = {word[10:5], 2'b00};
					result.blue        = {word[4:0], 3'b000};
					result.pixel_valid = 1'b1;
				end else begin
					result.out_of_row = 1'b1;
				end
				if (column_pos < DIM_W'(MAX_DIM)) begin
					column_pos_nxt = column_pos + DIM_W'(1);
				end
				pixels_left_nxt = (pixels_left != '0) ? (pixels_left - COUNT_W'(1)) : '0;
				if (pixels_left_nxt == '0) begin
					do_end_run = 1'b1;
				end
			end
			default: begin
				phase_nxt = PH_CODE;
			end
		endcase

		// Close a run; the last run closes the row.
		if (do_end_run) begin
			runs_left_nxt = (runs_left != '0) ? (runs_left - COUNT_W'(1)) : '0;
			if (runs_left_nxt == '0) begin
				do_finish = 1'b1;
			end else begin
				phase_nxt = PH_SKIP;
			end
		end

		// Close the row; the final row wraps the row count for a new image.
		if (do_finish) begin
			phase_nxt       = PH_CODE;
			column_pos_nxt  = '0;
			runs_left_nxt   = '0;
			pixels_left_nxt = '0;
			if (last_row) begin
				rows_done_nxt = '0;
				done          = 1'b1;
			end else begin
				rows_done_nxt = rows_done + DIM_W'(1);
			end
		end

		if (done) begin
			has_result        = 1'b1;
			result.image_done = 1'b1;
		end
	end

endmodule

// ===== hdl/sprite_row_run_decoder_core.sv =====
// ----------------------------------------------------------------------------
// sprite_row_run_decoder_core: skip/copy run-length sprite decoder
// Decodes a bottom-up, row-coded RGB565 sprite stream into per-pixel writes
// with row, column and RGB888 color, one stream word per clock when not stalled.
// ----------------------------------------------------------------------------
// The block takes one stream word per clock cycle, sustained, for as long as
// the result side keeps up. A word passes an input register, then the decode
// logic updates the row and run state and loads the result register once that
// register is free or drains; the pixel is sent on the result channel from the
// result register. Row codes, skip counts and copy counts give no result unless
// they close the final row of the image, in which case an end-of-image mark
// with no pixel is sent. The width and height registers may only be written
// while no words are in flight; they are clamped to 1..MAX_DIM internally.
module sprite_row_run_decoder_core #(
	parameter int MAX_DIM = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [srrd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [srrd_pkg::CFG_W-1:0]        cfg_data,
	srrd_stream_if.sink                       stream,
	srrd_result_if.source                     result
);
	import srrd_pkg::*;

	localparam int DIM_W = $clog2(MAX_DIM + 1);

	// Configuration registers.
	logic [CFG_W-1:0] image_width_q;
	logic [CFG_W-1:0] image_height_q;

	// Decoder state.
	srrd_phase_t      phase_q;
	logic [DIM_W-1:0] rows_done_q;
	logic [COUNT_W-1:0] runs_left_q;
	logic [COUNT_W-1:0] pixels_left_q;
	logic [DIM_W-1:0] column_pos_q;

	// Pipeline registers.
	logic              valid_s1;
	logic [WORD_W-1:0] word_s1;
	logic              valid_s2;
	srrd_result_t      res_s2;

	// Decode outputs.
	srrd_phase_t        phase_nxt;
	logic [DIM_W-1:0]   rows_done_nxt;
	logic [COUNT_W-1:0] runs_left_nxt;
	logic [COUNT_W-1:0] pixels_left_nxt;
	logic [DIM_W-1:0]   column_pos_nxt;
	logic               step_has_result;
	srrd_result_t       step_result;

	logic advance;

	// The held word is decoded when the result register is free or drains now.
	assign advance      = valid_s1 && (!valid_s2 || result.ready);
	assign stream.ready = !valid_s1 || advance;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IMAGE_WIDTH_RST;
			image_height_q <= IMAGE_HEIGHT_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.valid && stream.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			word_s1 <= stream.stream_word;
		end
	end

	// Decode logic.
	srrd_step #(
		.MAX_DIM (MAX_DIM)
	) u_step (
		.phase           (phase_q),
		.rows_done       (rows_done_q),
		.runs_left       (runs_left_q),
		.pixels_left     (pixels_left_q),
		.column_pos      (column_pos_q),
		.image_width     (image_width_q),
		.image_height    (image_height_q),
		.word            (word_s1),
		.phase_nxt       (phase_nxt),
		.rows_done_nxt   (rows_done_nxt),
		.runs_left_nxt   (runs_left_nxt),
		.pixels_left_nxt (pixels_left_nxt),
		.column_pos_nxt  (column_pos_nxt),
		.has_result      (step_has_result),
		.result          (step_result)
	);

	// Decoder state update, once per decoded word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_CODE;
			rows_done_q   <= '0;
			runs_left_q   <= '0;
			pixels_left_q <= '0;
			column_pos_q  <= '0;
		end else if (advance) begin
			phase_q       <= phase_nxt;
			rows_done_q   <= rows_done_nxt;
			runs_left_q   <= runs_left_nxt;
			pixels_left_q <= pixels_left_nxt;
			column_pos_q  <= column_pos_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= step_has_result;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= step_result;
		end
	end

	assign result.valid       = valid_s2;
	assign result.row         = res_s2.row;
	assign result.column      = res_s2.column;
	assign result.red         = res_s2.red;
	assign result.green       = res_s2.green;
	assign result.blue        = res_s2.blue;
	assign result.pixel_valid = res_s2.pixel_valid;
	assign result.out_of_row  = res_s2.out_of_row;
	assign result.image_done  = res_s2.image_done;

`ifndef SYNTH
	// A decoded pixel word always produces a result transaction.
	a_pixel_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && phase_q == PH_PIX) |=> valid_s2)
		else $error("pixel word decoded without a result");

	// An end-of-image result restarts the row count.
	a_done_wraps_rows: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step_has_result && step_result.image_done) |=> (rows_done_q == '0))
		else $error("row count not cleared at end of image");

	// While a row code is expected, the column position is at the row start.
	a_code_column_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_CODE) |-> (column_pos_q == '0))
		else $error("column position not cleared between rows");
`endif

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the sprite row run decoder core
// Drives coded sprite rows (blank, full and skip/copy rows) through the
// stream channel with random gaps. A scoreboard predicts every decoded pixel
// and end-of-image mark and checks each result transaction against it.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import srrd_pkg::*;

	localparam int MAX_DIM      = 1024;
	localparam int WORD_TARGET  = 1320;
	localparam int CALM_AFTER   = 1120;
	localparam int HOLD_AFTER   = 200;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 10;
	localparam int CYCLE_LIMIT  = 400000;

	// Predicts decoded pixels from accepted stream words and checks results.
	class row_run_scoreboard;
		logic [CFG_W-1:0]   width_reg;
		logic [CFG_W-1:0]   height_reg;
		srrd_phase_t        phase;
		logic [CFG_W-1:0]   rows_done;
		logic [COUNT_W-1:0] runs_left;
		logic [COUNT_W-1:0] pixels_left;
		logic [CFG_W-1:0]   column_pos;
		srrd_result_t       pending_pixels[$];
		int                 bad_pixels;

		function new();
			width_reg   = IMAGE_WIDTH_RST;
			height_reg  = IMAGE_HEIGHT_RST;
			phase       = PH_CODE;
			rows_done   = '0;
			runs_left   = '0;
			pixels_left = '0;
			column_pos  = '0;
			bad_pixels  = 0;
		endfunction

		function logic [CFG_W-1:0] clamp_dim(logic [CFG_W-1:0] v);
			if (v == 0)
				return CFG_W'(1);
			if (v > MAX_DIM)
				return CFG_W'(MAX_DIM);
			return v;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			if (idx == REG_IMAGE_WIDTH)
				width_reg = val;
			else
				height_reg = val;
		endfunction

		// Closes the current row; returns one when it was the last row of the image.
		function bit finish_row();
			logic [CFG_W-1:0] h;
			h = clamp_dim(height_reg);
			phase       = PH_CODE;
			column_pos  = '0;
			runs_left   = '0;
			pixels_left = '0;
			if (int'(rows_done) + 1 >= int'(h)) begin
				rows_done = '0;
				return 1;
			end
			rows_done = rows_done + CFG_W'(1);
			return 0;
		endfunction

		// Closes one skip/copy run and the row with it when no runs are left.
		function bit end_run();
			if (runs_left > 0)
				runs_left = runs_left - COUNT_W'(1);
			if (runs_left == 0)
				return finish_row();
			phase = PH_SKIP;
			return 0;
		endfunction

		// Steps the decoder state on one accepted stream word.
		function void note_word(logic [WORD_W-1:0] w);
			logic [CFG_W-1:0] wid;
			logic [CFG_W-1:0] h;
			bit               done;
			int unsigned      col_sum;
			srrd_result_t     pix;
			wid  = clamp_dim(width_reg);
			h    = clamp_dim(height_reg);
			done = 0;
			pix  = '0;
			case (phase)
				PH_CODE: begin
					column_pos = '0;
					if (w == CODE_BLANK_ROW) begin
						done = finish_row();
					end else if (w == CODE_FULL_ROW) begin
						runs_left   = COUNT_W'(1);
						pixels_left = COUNT_W'(wid);
						phase       = PH_PIX;
					end else begin
						runs_left = w - COUNT_W'(1);
						phase     = PH_SKIP;
					end
				end
				PH_SKIP: begin
					col_sum = 32'(column_pos) + 32'(w);
					column_pos = (col_sum > MAX_DIM) ? CFG_W'(MAX_DIM) : CFG_W'(col_sum);
					phase = PH_COPY;
				end
				PH_COPY: begin
					pixels_left = w;
					if (w == 0)
						done = end_run();
					else
						phase = PH_PIX;
				end
				default: begin
					// A pixel word always gives a result, dropped or not.
					pix.row    = (rows_done < h) ? POS_W'(h - 1 - rows_done) : '0;
					pix.column = column_pos[POS_W-1:0];
					if (column_pos < wid) begin
						pix.red         = {w[15:11], 3'b000};
						pix.green       = {w[10:5], 2'b00};
						pix.blue        = {w[4:0], 3'b000};
						pix.pixel_valid = 1'b1;
					end else begin
						pix.out_of_row = 1'b1;
					end
					if (column_pos < MAX_DIM)
						column_pos = column_pos + CFG_W'(1);
					if (pixels_left > 0)
						pixels_left = pixels_left - COUNT_W'(1);
					if (pixels_left == 0)
						done = end_run();
					pix.image_done = done;
					pending_pixels.push_back(pix);
					return;
				end
			endcase
			// A row end without a pixel only reports when it closes the image.
			if (done) begin
				pix.image_done = 1'b1;
				pending_pixels.push_back(pix);
			end
		endfunction

		// Compares one result transaction with the oldest prediction.
		function void check_pixel(srrd_result_t got);
			srrd_result_t want;
			if (pending_pixels.size() == 0) begin
				bad_pixels++;
				if (bad_pixels <= 10)
					$display("unexpected result: row %0d col %0d rgb %02h %02h %02h flags %b%b%b",
						got.row, got.column, got.red, got.green, got.blue,
						got.pixel_valid, got.out_of_row, got.image_done);
				return;
			end
			want = pending_pixels.pop_front();
			if (got.row !== want.row || got.column !== want.column ||
			    got.red !== want.red || got.green !== want.green ||
			    got.blue !== want.blue || got.pixel_valid !== want.pixel_valid ||
			    got.out_of_row !== want.out_of_row || got.image_done !== want.image_done) begin
				bad_pixels++;
				if (bad_pixels <= 10)
					$display("pixel mismatch: expected row %0d col %0d rgb %02h %02h %02h flags %b%b%b",
						want.row, want.column, want.red, want.green, want.blue,
						want.pixel_valid, want.out_of_row, want.image_done,
						"; got row %0d col %0d rgb %02h %02h %02h flags %b%b%b",
						got.row, got.column, got.red, got.green, got.blue,
						got.pixel_valid, got.out_of_row, got.image_done);
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	srrd_stream_if stream_ch();
	srrd_result_if result_ch();

	row_run_scoreboard board = new();
	logic [WORD_W-1:0] word_q[$];
	int                words_sent   = 0;
	int                results_seen = 0;
	int                cycles       = 0;
	int                sender_odds  = 0;
	bit                calm         = 0;
	bit                hold_done    = 0;

	sprite_row_run_decoder_core #(.MAX_DIM(MAX_DIM)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.stream    (stream_ch),
		.result    (result_ch)
	);

	always #6 clk = ~clk;

	// Run limit, far above the slowest legal run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Result monitor: every transaction is checked against the scoreboard.
	always @(posedge clk) begin
		srrd_result_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.row         = result_ch.row;
			got.column      = result_ch.column;
			got.red         = result_ch.red;
			got.green       = result_ch.green;
			got.blue        = result_ch.blue;
			got.pixel_valid = result_ch.pixel_valid;
			got.out_of_row  = result_ch.out_of_row;
			got.image_done  = result_ch.image_done;
			board.check_pixel(got);
			results_seen++;
		end
	end

	// Result side back-pressure: random stalls, quiet stretches and one long hold
	// that starts while the sender is offering words.
	initial begin
		result_ch.ready <= 1'b0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			@(posedge clk);
			if (!calm && !hold_done && results_seen >= HOLD_AFTER && stream_ch.valid) begin
				hold_done = 1;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				result_ch.ready <= 1'b1;
			end else if (!calm && $urandom_range(1, 8) == 1) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				result_ch.ready <= 1'b1;
			end else if ($urandom_range(1, 40) == 1) begin
				result_ch.ready <= 1'b1;
				repeat ($urandom_range(20, 120)) @(posedge clk);
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Sends every queued word, one transaction each, with optional gaps.
	task automatic play_words();
		logic [WORD_W-1:0] w;
		while (word_q.size() > 0) begin
			w = word_q.pop_front();
			if (!calm && sender_odds != 0 && $urandom_range(1, sender_odds) == 1) begin
				stream_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			stream_ch.valid       <= 1'b1;
			stream_ch.stream_word <= w;
			do
				@(posedge clk);
			while (!stream_ch.ready);
			board.note_word(w);
			words_sent++;
			if (words_sent >= CALM_AFTER)
				calm = 1;
		end
	endtask

	// Stops offering words and waits until the block has gone quiet.
	task automatic settle();
		stream_ch.valid <= 1'b0;
		while (board.pending_pixels.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes width then height on consecutive cycles while the block is idle.
	task automatic apply_settings(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		cfg_wen   <= 1'b1;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		cfg_wen <= 1'b0;
		board.set_register(REG_IMAGE_WIDTH, w);
		board.set_register(REG_IMAGE_HEIGHT, h);
	endtask

	// Picks a register value: mostly typical sizes, sometimes the extremes.
	function automatic logic [CFG_W-1:0] pick_dim(int typical);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return CFG_W'(MAX_DIM);
			3: return CFG_W'($urandom_range(0, 2047));
			default: return CFG_W'($urandom_range(1, typical));
		endcase
	endfunction

	// Queues one well-formed coded row with random content.
	function automatic void push_row(int wid);
		int kind;
		int nruns;
		int skip;
		int copy;
		kind = $urandom_range(0, 9);
		if (kind < 2) begin
			word_q.push_back(CODE_BLANK_ROW);
		end else if (kind < 4 && wid <= 64) begin
			word_q.push_back(CODE_FULL_ROW);
			repeat (wid) word_q.push_back(WORD_W'($urandom()));
		end else begin
			nruns = $urandom_range(1, 4);
			word_q.push_back(WORD_W'(nruns + 1));
			repeat (nruns) begin
				case ($urandom_range(0, 9))
					0: skip = 0;
					1: skip = $urandom_range(0, 65535);
					2: skip = wid;
					default: skip = $urandom_range(0, wid);
				endcase
				copy = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8);
				word_q.push_back(WORD_W'(skip));
				word_q.push_back(WORD_W'(copy));
				repeat (copy) word_q.push_back(WORD_W'($urandom()));
			end
		end
	endfunction

	initial begin
		logic [CFG_W-1:0] w;
		logic [CFG_W-1:0] h;
		int               p;
		stream_ch.valid       <= 1'b0;
		stream_ch.stream_word <= '0;
		cfg_wen               <= 1'b0;
		cfg_index             <= '0;
		cfg_data              <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows at reset settings: run over the row end with dropped
		// pixels and color extremes, then a zero copy in the first run, a
		// saturating skip and a blank row.
		word_q = '{16'd2, 16'd126, 16'd4, 16'h0000, 16'hFFFF, 16'hF800, 16'h07E0,
			16'd4, 16'd0, 16'd0, 16'd1, 16'd1, 16'h001F, 16'hFFFF, 16'd1, 16'hAAAA,
			CODE_BLANK_ROW};
		play_words();

		// Height lowered below the rows already done: the next row end closes
		// the image. Width zero is taken as one.
		settle();
		apply_settings('0, 11'd2);
		word_q = '{CODE_FULL_ROW, 16'h5555};
		play_words();

		// One-row image closed by a blank row, then by a zero copy count.
		settle();
		apply_settings('1, 11'd1);
		word_q = '{CODE_BLANK_ROW, 16'd2, 16'd3, 16'd0};
		play_words();

		// Random phases: extremes of both registers first, then mixed sizes.
		p = 0;
		while (words_sent < WORD_TARGET) begin
			case (p)
				0: begin w = '1; h = '1; end
				1: begin w = '0; h = '0; end
				2: begin w = CFG_W'(MAX_DIM); h = CFG_W'(MAX_DIM); end
				3: begin w = 11'd1; h = 11'd1; end
				default: begin w = pick_dim(40); h = pick_dim(6); end
			endcase
			settle();
			apply_settings(w, h);
			case ($urandom_range(0, 2))
				0: sender_odds = 0;
				1: sender_odds = 3;
				default: sender_odds = 10;
			endcase
			repeat ($urandom_range(3, 12)) push_row(int'(board.clamp_dim(w)));
			play_words();
			p++;
		end

		settle();
		if (board.bad_pixels == 0 && board.pending_pixels.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
